/* hdl/rnup_pkg.sv */
// shared types, codes and constants for the radio node upload protocol block
package rnup_pkg;

  localparam int unsigned CHUNK_MAX = 255;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 56;

  typedef enum logic [3:0] {
    ST_STARTING    = 4'd0,
    ST_IDLE        = 4'd1,
    ST_SLEEPING    = 4'd2,
    ST_LISTEN      = 4'd3,
    ST_PING        = 4'd4,
    ST_WAIT_PONG   = 4'd5,
    ST_PREPARE     = 4'd6,
    ST_WAIT_READY  = 4'd7,
    ST_READ        = 4'd8,
    ST_SEND_DATA   = 4'd9,
    ST_WAIT_MORE   = 4'd10,
    ST_SEND_CLOSE  = 4'd11,
    ST_WAIT_CLOSED = 4'd12,
    ST_FAILURE     = 4'd13
  } proto_state_t;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_PACKET = 2'd1,
    OP_SEND   = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  localparam logic [2:0] KIND_PING    = 3'd0;
  localparam logic [2:0] KIND_PONG    = 3'd1;
  localparam logic [2:0] KIND_PREPARE = 3'd2;
  localparam logic [2:0] KIND_ACK     = 3'd3;
  localparam logic [2:0] KIND_DATA    = 3'd4;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_IDLE  = 2'd1;
  localparam logic [1:0] MODE_RX    = 2'd2;
  localparam logic [1:0] MODE_SLEEP = 2'd3;

  localparam logic [1:0] REG_NODE_ID        = 2'd0;
  localparam logic [1:0] REG_LISTEN_WINDOW  = 2'd1;
  localparam logic [1:0] REG_RECEIVE_WINDOW = 2'd2;
  localparam logic [1:0] REG_RETRY_LIMIT    = 2'd3;

  typedef struct packed {
    logic [15:0] node_id;
    logic [15:0] listen_window;
    logic [15:0] receive_window;
    logic [3:0]  retry_limit;
  } cfg_t;

  typedef struct packed {
    opcode_t            opcode;
    logic               packet_ok;
    logic [2:0]         packet_kind;
    logic [15:0]        packet_node;
    logic signed [8:0]  read_result;
    logic [15:0]        idle_delay;
    logic               radio_in_tx;
  } item_t;

  typedef struct packed {
    proto_state_t proto;
    logic [15:0]  ticks_in_state;
    logic [15:0]  idle_countdown;
    logic [3:0]   retry_count;
    logic [31:0]  sequence_reg;
    logic [7:0]   chunk_length;
    logic         reader_open;
  } ctx_t;

  typedef struct packed {
    logic [3:0]  proto_state;
    logic        send_valid;
    logic [2:0]  send_kind;
    logic [7:0]  send_length;
    logic [1:0]  radio_mode;
    logic        reopen_reader;
    logic        read_request;
    logic [31:0] sequence_number;
  } result_t;

endpackage

/* hdl/rnup_in_reg.sv */
// input register stage holding one event item
module rnup_in_reg import rnup_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic [IN_TUSER_W-1:0] s_tuser,
  input  logic                  take,
  output logic                  valid,
  output item_t                 item
);

  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.opcode      <= opcode_t'(s_tuser);
      item.packet_ok   <= s_tdata[0];
      item.packet_kind <= s_tdata[3:1];
      item.packet_node <= s_tdata[19:4];
      item.read_result <= s_tdata[28:20];
      item.idle_delay  <= s_tdata[44:29];
      item.radio_in_tx <= s_tdata[45];
    end
  end

endmodule

/* hdl/rnup_step.sv */
// next protocol context and result for one event
module rnup_step import rnup_pkg::*; (
  input  cfg_t    cfg,
  input  ctx_t    ctx,
  input  item_t   item,
  output ctx_t    ctx_next,
  output result_t res
);

  logic [15:0] ticks_inc;
  logic [15:0] idle_dec;
  logic        traffic;
  logic        rx_timeout;
  logic        can_retry;
  logic [7:0]  read_len;

  assign ticks_inc  = (ctx.ticks_in_state != 16'hFFFF) ? ctx.ticks_in_state + 16'd1
                                                       : ctx.ticks_in_state;
  assign idle_dec   = (ctx.idle_countdown != 16'd0) ? ctx.idle_countdown - 16'd1 : 16'd0;
  assign traffic    = (item.packet_kind != KIND_ACK) && (item.packet_node != cfg.node_id);
  assign rx_timeout = ticks_inc >= cfg.receive_window;
  assign can_retry  = ctx.retry_count < cfg.retry_limit;
  // saturate chunk length to the largest chunk
  assign read_len   = ({1'b0, item.read_result[7:0]} > 9'(CHUNK_MAX)) ? 8'(CHUNK_MAX)
                                                                   : item.read_result[7:0];

  always_comb begin
    ctx_next = ctx;
    res      = '0;

    unique case (item.opcode)
      OP_TICK: begin
        ctx_next.ticks_in_state = ticks_inc;
        unique case (ctx.proto)
          ST_STARTING: begin
            ctx_next.retry_count    = 4'd0;
            ctx_next.proto          = ST_SLEEPING;
            ctx_next.ticks_in_state = 16'd0;
          end
          ST_IDLE: begin
            res.radio_mode          = MODE_IDLE;
            ctx_next.idle_countdown = idle_dec;
            if (idle_dec == 16'd0) begin
              ctx_next.proto          = ST_LISTEN;
              ctx_next.ticks_in_state = 16'd0;
            end
          end
          ST_SLEEPING: begin
            res.radio_mode = MODE_SLEEP;
          end
          ST_LISTEN: begin
            ctx_next.retry_count = 4'd0;
            res.radio_mode       = MODE_RX;
            if (ticks_inc >= cfg.listen_window) begin
              ctx_next.proto          = ST_PING;
              ctx_next.ticks_in_state = 16'd0;
            end
          end
          ST_PING: begin
            res.send_valid          = 1'b1;
            res.send_kind           = KIND_PING;
            ctx_next.proto          = ST_WAIT_PONG;
            ctx_next.ticks_in_state = 16'd0;
          end
          ST_WAIT_PONG: begin
            if (!item.radio_in_tx) begin
              res.radio_mode = MODE_RX;
            end
            if (rx_timeout) begin
              ctx_next.proto          = ST_LISTEN;
              ctx_next.ticks_in_state = 16'd0;
            end
          end
          ST_PREPARE: begin
            res.reopen_reader       = 1'b1;
            ctx_next.reader_open    = 1'b1;
            res.send_valid          = 1'b1;
            res.send_kind           = KIND_PREPARE;
            ctx_next.proto          = ST_WAIT_READY;
            ctx_next.ticks_in_state = 16'd0;
          end
          ST_WAIT_READY, ST_WAIT_MORE, ST_WAIT_CLOSED: begin
            if (!item.radio_in_tx) begin
              res.radio_mode = MODE_RX;
            end
            if (rx_timeout) begin
              ctx_next.ticks_in_state = 16'd0;
              if (can_retry) begin
                ctx_next.retry_count = ctx.retry_count + 4'd1;
                // resend whatever this window was waiting on
                unique case (ctx.proto)
                  ST_WAIT_READY: ctx_next.proto = ST_PREPARE;
                  ST_WAIT_MORE:  ctx_next.proto = ST_SEND_DATA;
                  default:       ctx_next.proto = ST_SEND_CLOSE;
                endcase
              end else begin
                ctx_next.proto = ST_FAILURE;
              end
            end
          end
          ST_READ: begin
            if (item.read_result[8]) begin
              ctx_next.proto          = ST_SEND_CLOSE;
              ctx_next.ticks_in_state = 16'd0;
            end else if (item.read_result[7:0] != 8'd0) begin
              ctx_next.chunk_length   = read_len;
              ctx_next.proto          = ST_SEND_DATA;
              ctx_next.ticks_in_state = 16'd0;
            end else begin
              res.read_request = 1'b1;
            end
          end
          ST_SEND_DATA: begin
            res.send_valid          = 1'b1;
            res.send_kind           = KIND_DATA;
            res.send_length         = ctx.chunk_length;
            ctx_next.proto          = ST_WAIT_MORE;
            ctx_next.ticks_in_state = 16'd0;
          end
          ST_SEND_CLOSE: begin
            res.send_valid          = 1'b1;
            res.send_kind           = KIND_DATA;
            ctx_next.proto          = ST_WAIT_CLOSED;
            ctx_next.ticks_in_state = 16'd0;
          end
          default: begin
          end
        endcase
      end
      OP_PACKET: begin
        if (item.packet_ok) begin
          unique case (ctx.proto)
            ST_LISTEN: begin
              if (traffic) begin
                ctx_next.proto          = ST_SLEEPING;
                ctx_next.ticks_in_state = 16'd0;
              end
            end
            ST_WAIT_PONG: begin
              if (item.packet_kind == KIND_PONG) begin
                ctx_next.retry_count    = 4'd0;
                ctx_next.proto          = ST_PREPARE;
                ctx_next.ticks_in_state = 16'd0;
              end
            end
            ST_WAIT_READY: begin
              if (item.packet_kind == KIND_ACK) begin
                ctx_next.sequence_reg   = 32'd1;
                ctx_next.retry_count    = 4'd0;
                ctx_next.proto          = ST_READ;
                ctx_next.ticks_in_state = 16'd0;
                res.read_request        = 1'b1;
              end
            end
            ST_WAIT_MORE: begin
              if (item.packet_kind == KIND_ACK) begin
                ctx_next.sequence_reg   = ctx.sequence_reg + 32'd1;
                ctx_next.retry_count    = 4'd0;
                ctx_next.proto          = ST_READ;
                ctx_next.ticks_in_state = 16'd0;
                res.read_request        = 1'b1;
              end
            end
            ST_WAIT_CLOSED: begin
              if (item.packet_kind == KIND_ACK) begin
                ctx_next.sequence_reg   = ctx.sequence_reg + 32'd1;
                ctx_next.retry_count    = 4'd0;
                ctx_next.proto          = ST_SLEEPING;
                ctx_next.ticks_in_state = 16'd0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      OP_SEND: begin
        ctx_next.proto          = ST_IDLE;
        ctx_next.ticks_in_state = 16'd0;
        ctx_next.idle_countdown = item.idle_delay;
      end
      default: begin
      end
    endcase

    res.proto_state     = ctx_next.proto;
    res.sequence_number = ctx_next.sequence_reg;
  end

endmodule

/* hdl/rnup_out_reg.sv */
// result register toward the output stream
module rnup_out_reg import rnup_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  result_t                res,
  output logic                   can_load,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output result_t                held
);

  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {4'd0, held.sequence_number, held.read_request, held.reopen_reader,
                    held.radio_mode, held.send_length, held.send_kind, held.send_valid,
                    held.proto_state};

endmodule

/* hdl/radio_node_upload_protocol_top.sv */
// top level of the radio node upload protocol block
//
// node side of a radio upload exchange: each input item is one event (tick,
// received packet or send request) and produces exactly one result item with
// the protocol state after the event, the packet to transmit if any, the radio
// command, reader pulses and the acknowledged sequence number. an item is held in
// the input register until the event logic updates the protocol context and
// loads the result register in the same cycle, so the block takes one item per
// clock as long as the output side keeps taking results; each result is held
// in the result register and presented until it is taken. the input register
// refills in the cycle the result register loads, so a stalled output holds
// back at most one item. configuration registers are written through a plain
// write port; the user must write them only while no item is in flight, the
// block itself does not enforce this.
module radio_node_upload_protocol_top import rnup_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // config write port
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  // event items
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // packet_ok, packet_kind[3:1], packet_node[19:4], read_result[28:20],
  // idle_delay[44:29], radio_in_tx[45], zero fill
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // opcode
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  // result items
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // proto_state[3:0], send_valid[4], send_kind[7:5], send_length[15:8],
  // radio_mode[17:16], reopen_reader[18], read_request[19],
  // sequence_number[51:20], zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  cfg_t    cfg;
  ctx_t    ctx;
  ctx_t    ctx_next;
  item_t   item;
  result_t res;
  result_t held;
  logic    in_valid;
  logic    can_load;
  logic    fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_id        <= 16'd0;
      cfg.listen_window  <= 16'd100;
      cfg.receive_window <= 16'd100;
      cfg.retry_limit    <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_ID:        cfg.node_id        <= cfg_data;
        REG_LISTEN_WINDOW:  cfg.listen_window  <= cfg_data;
        REG_RECEIVE_WINDOW: cfg.receive_window <= cfg_data;
        REG_RETRY_LIMIT:    cfg.retry_limit    <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  rnup_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .take     (fire),
    .valid    (in_valid),
    .item     (item)
  );

  // an event is processed when the result register has room
  assign fire = in_valid && can_load;

  rnup_step u_step (
    .cfg      (cfg),
    .ctx      (ctx),
    .item     (item),
    .ctx_next (ctx_next),
    .res      (res)
  );

  // protocol context, advanced once per processed event
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.proto          <= ST_STARTING;
      ctx.ticks_in_state <= 16'd0;
      ctx.idle_countdown <= 16'd0;
      ctx.retry_count    <= 4'd0;
      ctx.sequence_reg   <= 32'd0;
      ctx.chunk_length   <= 8'd0;
      ctx.reader_open    <= 1'b0;
    end else if (fire) begin
      ctx <= ctx_next;
    end
  end

  rnup_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .held     (held)
  );

  // a packet only goes out on the way into a waiting window
  a_send_enters_wait: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && held.send_valid |->
      held.proto_state == ST_WAIT_PONG || held.proto_state == ST_WAIT_READY ||
      held.proto_state == ST_WAIT_MORE || held.proto_state == ST_WAIT_CLOSED)
    else $error("packet sent without entering a waiting state");

  // reopening the reader goes with the prepare packet
  a_reopen_with_prepare: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && held.reopen_reader |-> held.send_valid && held.send_kind == KIND_PREPARE)
    else $error("reader reopened without a prepare packet");

  // the sequence counter moves only when an event is processed
  a_seq_only_on_fire: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(ctx.sequence_reg))
    else $error("sequence counter changed without an event");

  // a read request never leaves the state machine outside the read step
  a_read_req_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && held.read_request |-> held.proto_state == ST_READ)
    else $error("read requested outside the read state");

endmodule
